>>> src/twcs_pkg.sv
// Shared types, constants and codes for the textured wall column stepper.
package twcs_pkg;

    localparam int SCREEN_HEIGHT_DEF = 1024;

    localparam int COL_W   = 10;
    localparam int SPAN_W  = 11;
    localparam int LH_W    = 16;
    localparam int FRAC_W  = 16;
    localparam int FACE_W  = 2;
    localparam int COLOR_W = 24;
    localparam int TW_W    = 11;
    localparam int HLOG_W  = 4;
    localparam int TEX_W   = 10;
    localparam int ROWO_W  = 10;
    localparam int POS_W   = 48;
    localparam int FRAC_SH = 16;

    localparam int TEX_WIDTH_MAX = 1024;
    localparam int HLOG_MAX      = 10;
    localparam int TEX_WIDTH_RST = 64;
    localparam int HLOG_RST      = 6;

    // Step is 2^(h+16) / line height, at most 2^26.
    localparam int QUO_W = HLOG_MAX + FRAC_SH + 1;
    // Signed start offset 2*span_start - screen height + line height.
    localparam int N_W   = 18;

    localparam int CMDQ_DEPTH = 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THLOG   = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        RG_CEILING = 2'd0,
        RG_WALL    = 2'd1,
        RG_FLOOR   = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV,
        BK_MUL
    } t_bstate;

    typedef struct packed {
        logic              kind;
        logic [COL_W-1:0]  column;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic [LH_W-1:0]   wall_rows;
        logic [FRAC_W-1:0] wall_fraction;
        logic [FACE_W-1:0] face;
        logic              mirror;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] ceiling_color;
        logic [COLOR_W-1:0] floor_color;
        logic [TW_W-1:0]    tex_width;
        logic [HLOG_W-1:0]  tex_hlog;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROWO_W-1:0]  row;
        t_region            region;
        logic [COLOR_W-1:0] flat_color;
        logic [TEX_W-1:0]   texel_column;
        logic [TEX_W-1:0]   texel_row;
        logic [FACE_W-1:0]  face;
        logic               last;
    } t_pix;

endpackage

>>> src/twcs_front.sv
// Front end: accepts input words, classifies them and queues commands.
module twcs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_kind,
    input  logic [twcs_pkg::COL_W-1:0]  i_column,
    input  logic [twcs_pkg::SPAN_W-1:0] i_span_start,
    input  logic [twcs_pkg::SPAN_W-1:0] i_span_end,
    input  logic [twcs_pkg::LH_W-1:0]   i_wall_rows,
    input  logic [twcs_pkg::FRAC_W-1:0] i_wall_fraction,
    input  logic [twcs_pkg::FACE_W-1:0] i_face,
    input  logic                        i_ray_x_positive,
    input  logic                        i_ray_y_positive,
    output logic                        o_cmd_valid,
    output twcs_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_take
);
    import twcs_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_cmd             w_cmd;
    logic             w_wr;
    logic             w_rd;

    // North/south faces mirror on positive x, east/west on positive y.
    always_comb begin
        w_cmd.kind          = i_kind;
        w_cmd.column        = i_column;
        w_cmd.span_start    = i_span_start;
        w_cmd.span_end      = i_span_end;
        w_cmd.wall_rows     = (i_wall_rows == '0) ? LH_W'(1) : i_wall_rows;
        w_cmd.wall_fraction = i_wall_fraction;
        w_cmd.face          = i_face;
        w_cmd.mirror        = i_face[1] ? i_ray_y_positive : i_ray_x_positive;
    end

    assign o_full      = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> src/twcs_div.sv
// Radix-2 restoring divider for the texture step 2^(h+16) / line height.
module twcs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [twcs_pkg::HLOG_W-1:0] i_hlog,
    input  logic [twcs_pkg::LH_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [twcs_pkg::QUO_W-1:0]  o_quotient
);
    import twcs_pkg::*;

    localparam int IDX_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [IDX_W-1:0] r_idx;
    logic [LH_W-1:0]  r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             w_bit;
    logic [LH_W:0]    w_trial;
    logic             w_ge;
    logic [LH_W-1:0]  w_rem_n;

    // The dividend is a single one bit at position h+16.
    assign w_bit   = (r_idx == IDX_W'(i_hlog) + IDX_W'(FRAC_SH));
    assign w_trial = {r_rem, w_bit};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_rem_n = w_ge ? LH_W'(w_trial - {1'b0, i_divisor}) : w_trial[LH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_idx == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= IDX_W'(QUO_W - 1);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx - 1'b1;
            r_rem <= w_rem_n;
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/twcs_back.sv
// Back end: column setup sequencer and per-row pixel datapath with result register.
module twcs_back #(
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  twcs_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  twcs_pkg::t_cfg i_cfg,
    input  logic           i_pop,
    output logic           o_valid,
    output twcs_pkg::t_pix o_pix
);
    import twcs_pkg::*;

    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int PROD_W = N_W + QUO_W + 1;

    t_bstate            r_state;
    t_bstate            n_state;
    logic               r_active;
    logic [ROW_W-1:0]   r_row;
    logic               r_out_valid;
    t_pix               r_out;
    logic [POS_W-1:0]   r_pos;
    logic [QUO_W-1:0]   r_step;
    logic [TEX_W-1:0]   r_tcol;
    logic [SPAN_W-1:0]  r_ss;
    logic [SPAN_W-1:0]  r_se;
    logic [FACE_W-1:0]  r_face;
    logic [COL_W-1:0]   r_col;
    logic [LH_W-1:0]    r_lh;

    logic               w_take;
    logic               w_div_start;
    logic               w_emit;
    logic               w_out_free;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_quo;
    logic               w_is_load;
    logic [FRAC_W+TW_W-1:0] w_tc_prod;
    logic [TW_W-1:0]    w_tc;
    logic [TW_W-1:0]    w_tc_mir;
    logic signed [N_W-1:0]    w_n;
    logic signed [PROD_W-1:0] w_prod;
    logic [SPAN_W-1:0]  w_row_ext;
    logic               w_last;
    logic [TEX_W-1:0]   w_trow_raw;
    logic [TEX_W-1:0]   w_hmask;
    t_pix               n_pix;

    twcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_hlog     (i_cfg.tex_hlog),
        .i_divisor  (r_lh),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_is_load  = (i_cmd.kind == KIND_LOAD);
    assign w_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (i_cmd_valid && w_is_load) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (w_div_done) n_state = BK_MUL;
            end
            BK_MUL: begin
                n_state = BK_RUN;
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_comb begin
        w_take      = 1'b0;
        w_div_start = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            BK_RUN: begin
                if (i_cmd_valid) begin
                    if (w_is_load) begin
                        w_take      = 1'b1;
                        w_div_start = 1'b1;
                    end else if (!r_active) begin
                        w_take = 1'b1;
                    end else if (w_out_free) begin
                        w_take = 1'b1;
                        w_emit = 1'b1;
                    end
                end
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
    end

    // Texture column from the hit fraction, mirrored where the ray runs positive.
    assign w_tc_prod = i_cmd.wall_fraction * i_cfg.tex_width;
    assign w_tc      = {1'b0, w_tc_prod[FRAC_SH +: TEX_W]};
    assign w_tc_mir  = i_cfg.tex_width - TW_W'(1) - w_tc;

    assign w_n    = $signed(N_W'({r_ss, 1'b0})) + $signed(N_W'(r_lh))
                  - $signed(N_W'(SCREEN_HEIGHT));
    assign w_prod = w_n * $signed({1'b0, r_step});

    // Integer part truncated toward zero, low bits only.
    assign w_trow_raw = r_pos[FRAC_SH +: TEX_W]
                      + TEX_W'(r_pos[POS_W-1] && (r_pos[FRAC_SH-1:0] != '0));
    assign w_hmask    = TEX_W'((11'd1 << i_cfg.tex_hlog) - 11'd1);
    assign w_row_ext  = SPAN_W'(r_row);
    assign w_last     = (r_row == ROW_W'(SCREEN_HEIGHT - 1));

    always_comb begin
        n_pix.column       = r_col;
        n_pix.row          = ROWO_W'(r_row);
        n_pix.face         = r_face;
        n_pix.last         = w_last;
        n_pix.region       = RG_FLOOR;
        n_pix.flat_color   = i_cfg.floor_color;
        n_pix.texel_column = '0;
        n_pix.texel_row    = '0;
        if (w_row_ext < r_ss) begin
            n_pix.region     = RG_CEILING;
            n_pix.flat_color = i_cfg.ceiling_color;
        end else if (w_row_ext < r_se) begin
            n_pix.region       = RG_WALL;
            n_pix.flat_color   = '0;
            n_pix.texel_column = r_tcol;
            n_pix.texel_row    = w_trow_raw & w_hmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_active    <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_div_start) begin
                r_active <= 1'b1;
                r_row    <= '0;
            end else if (w_emit) begin
                if (w_last) begin
                    r_active <= 1'b0;
                    r_row    <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_col  <= i_cmd.column;
            r_ss   <= i_cmd.span_start;
            r_se   <= i_cmd.span_end;
            r_face <= i_cmd.face;
            r_lh   <= i_cmd.wall_rows;
            r_tcol <= i_cmd.mirror ? w_tc_mir[TEX_W-1:0] : w_tc[TEX_W-1:0];
        end
        if (r_state == BK_DIV && w_div_done) begin
            r_step <= w_quo;
        end
        if (r_state == BK_MUL) begin
            r_pos <= POS_W'(w_prod >>> 1);
        end else if (w_emit && n_pix.region == RG_WALL) begin
            r_pos <= r_pos + POS_W'(r_step);
        end
        if (w_emit) begin
            r_out <= n_pix;
        end
    end

    assign o_cmd_take = w_take;
    assign o_valid    = r_out_valid;
    assign o_pix      = r_out;

endmodule

>>> src/textured_wall_column_stepper_unit.sv
// Top level of the textured wall column stepper: configuration registers and wiring.
//
//  channel   direction  handshake             word
//  input     in         push / full           kind, column, span, line height, hit, face, signs
//  result    out        empty / pop           column, row, region, colors, texel, face, last
//  config    in         i_cfg_we (no wait)    register index and data
//
// A tick on an active column yields one pixel per cycle while the result register drains.
// A load word is latched, then runs through the bit-serial step divider, the quotient
// hand-over and the start multiply before the next word is taken.
// Reset is synchronous and active low; it empties both queues and ends the column.
// Input stalls only when the two-entry command queue is full; a stalled result
// holds the pixel path while ticks wait in that queue.
module textured_wall_column_stepper_unit #(
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_kind,
    input  logic [twcs_pkg::COL_W-1:0]     i_column,
    input  logic [twcs_pkg::SPAN_W-1:0]    i_span_start,
    input  logic [twcs_pkg::SPAN_W-1:0]    i_span_end,
    input  logic [twcs_pkg::LH_W-1:0]      i_wall_rows,
    input  logic [twcs_pkg::FRAC_W-1:0]    i_wall_fraction,
    input  logic [twcs_pkg::FACE_W-1:0]    i_face,
    input  logic                           i_ray_x_positive,
    input  logic                           i_ray_y_positive,
    output logic                           empty,
    input  logic                           pop,
    output logic [twcs_pkg::COL_W-1:0]     o_out_column,
    output logic [twcs_pkg::ROWO_W-1:0]    o_row,
    output logic [1:0]                     o_region,
    output logic [twcs_pkg::COLOR_W-1:0]   o_flat_color,
    output logic [twcs_pkg::TEX_W-1:0]     o_texel_column,
    output logic [twcs_pkg::TEX_W-1:0]     o_texel_row,
    output logic [twcs_pkg::FACE_W-1:0]    o_out_face,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [twcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [twcs_pkg::COLOR_W-1:0]   i_cfg_data
);
    import twcs_pkg::*;

    t_cfg            r_cfg;
    logic            w_cmd_valid;
    t_cmd            w_cmd;
    logic            w_cmd_take;
    logic            w_out_valid;
    t_pix            w_pix;
    logic [TW_W-1:0] w_tw;
    logic [HLOG_W-1:0] w_hl;

    // Store the effective values: zero width acts as one, wide values clamp.
    assign w_tw = i_cfg_data[TW_W-1:0];
    assign w_hl = i_cfg_data[HLOG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceiling_color <= '0;
            r_cfg.floor_color   <= '0;
            r_cfg.tex_width     <= TW_W'(TEX_WIDTH_RST);
            r_cfg.tex_hlog      <= HLOG_W'(HLOG_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CEILING: begin
                    r_cfg.ceiling_color <= i_cfg_data;
                end
                CFG_FLOOR: begin
                    r_cfg.floor_color <= i_cfg_data;
                end
                CFG_TWIDTH: begin
                    if (w_tw == '0) begin
                        r_cfg.tex_width <= TW_W'(1);
                    end else if (w_tw > TW_W'(TEX_WIDTH_MAX)) begin
                        r_cfg.tex_width <= TW_W'(TEX_WIDTH_MAX);
                    end else begin
                        r_cfg.tex_width <= w_tw;
                    end
                end
                CFG_THLOG: begin
                    r_cfg.tex_hlog <= (w_hl > HLOG_W'(HLOG_MAX)) ? HLOG_W'(HLOG_MAX) : w_hl;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    twcs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_kind           (i_kind),
        .i_column         (i_column),
        .i_span_start     (i_span_start),
        .i_span_end       (i_span_end),
        .i_wall_rows      (i_wall_rows),
        .i_wall_fraction  (i_wall_fraction),
        .i_face           (i_face),
        .i_ray_x_positive (i_ray_x_positive),
        .i_ray_y_positive (i_ray_y_positive),
        .o_cmd_valid      (w_cmd_valid),
        .o_cmd            (w_cmd),
        .i_cmd_take       (w_cmd_take)
    );

    twcs_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_cfg       (r_cfg),
        .i_pop       (pop && w_out_valid),
        .o_valid     (w_out_valid),
        .o_pix       (w_pix)
    );

    // Drive the result word straight from the back end's output register.
    assign empty          = !w_out_valid;
    assign o_out_column   = w_pix.column;
    assign o_row          = w_pix.row;
    assign o_region       = w_pix.region;
    assign o_flat_color   = w_pix.flat_color;
    assign o_texel_column = w_pix.texel_column;
    assign o_texel_row    = w_pix.texel_row;
    assign o_out_face     = w_pix.face;
    assign o_last         = w_pix.last;

endmodule

>>> src/twcs_checker.sv
// Port-level checks for the stepper, bound onto the top level.
module twcs_checker #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [9:0]  o_out_column,
    input logic [9:0]  o_row,
    input logic [1:0]  o_region,
    input logic [23:0] o_flat_color,
    input logic [9:0]  o_texel_column,
    input logic [9:0]  o_texel_row,
    input logic        o_last
);

    // Reset drops any waiting pixel.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row) && $stable(o_out_column)
                              && $stable(o_region)))
        else $error("waiting pixel changed before pop");

    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_region == 2'd0 || o_region == 2'd1 || o_region == 2'd2))
        else $error("illegal region code");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_region == 2'd1) ? (o_flat_color == 24'd0)
                                       : (o_texel_row == 10'd0 && o_texel_column == 10'd0)))
        else $error("flat color and texel fields both set");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_row == 10'(SCREEN_HEIGHT - 1)))
        else $error("last flag away from bottom row");

endmodule

bind textured_wall_column_stepper_unit twcs_checker #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_twcs_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the textured wall column stepper: random columns, pixel predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twcs_pkg::*;

    // Keep the default screen height so the row output spans its full range.
    localparam int SCREEN_ROWS    = SCREEN_HEIGHT_DEF;
    localparam int RAND_PER_PHASE = 90;    // random load/tick words per phase, besides the full column
    localparam int LONG_HOLD      = 400;   // cycles the receiver holds pop low once
    localparam int DRAIN_TAIL     = 40;    // covers the load pipeline
    localparam int STALL_LIMIT    = 4000;  // cycles without any handshake before giving up
    localparam int PRINT_CAP      = 60;

    // One input word, as the sender sees it.
    typedef struct packed {
        logic              kind;
        logic [COL_W-1:0]  column;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic [LH_W-1:0]   wall_rows;
        logic [FRAC_W-1:0] wall_fraction;
        logic [FACE_W-1:0] face;
        logic              ray_x_positive;
        logic              ray_y_positive;
    } t_word;

    // DUT ports; every input starts at a known value.
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 push             = 1'b0;
    logic                 full;
    logic                 i_kind           = KIND_TICK;
    logic [COL_W-1:0]     i_column         = '0;
    logic [SPAN_W-1:0]    i_span_start     = '0;
    logic [SPAN_W-1:0]    i_span_end       = '0;
    logic [LH_W-1:0]      i_wall_rows      = '0;
    logic [FRAC_W-1:0]    i_wall_fraction  = '0;
    logic [FACE_W-1:0]    i_face           = '0;
    logic                 i_ray_x_positive = 1'b0;
    logic                 i_ray_y_positive = 1'b0;
    logic                 empty;
    logic                 pop              = 1'b0;
    logic [COL_W-1:0]     o_out_column;
    logic [ROWO_W-1:0]    o_row;
    logic [1:0]           o_region;
    logic [COLOR_W-1:0]   o_flat_color;
    logic [TEX_W-1:0]     o_texel_column;
    logic [TEX_W-1:0]     o_texel_row;
    logic [FACE_W-1:0]    o_out_face;
    logic                 o_last;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = CFG_CEILING;
    logic [COLOR_W-1:0]   i_cfg_data       = '0;

    textured_wall_column_stepper_unit #(
        .SCREEN_HEIGHT(SCREEN_ROWS)
    ) u_dut (.*);

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pixel predictor: register mirror and column state, reset values.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] cfg_ceiling = '0;
    logic [COLOR_W-1:0] cfg_floor   = '0;
    logic [TW_W-1:0]    cfg_twidth  = TW_W'(TEX_WIDTH_RST);
    logic [HLOG_W-1:0]  cfg_thlog   = HLOG_W'(HLOG_RST);

    bit                 col_active = 1'b0;
    int unsigned        row_cnt    = 0;
    logic [POS_W-1:0]   tex_pos    = '0;
    logic [31:0]        step_q16   = '0;
    logic [TEX_W-1:0]   hold_tcol  = '0;
    int unsigned        hold_start = 0;
    int unsigned        hold_end   = 0;
    logic [FACE_W-1:0]  hold_face  = '0;
    logic [COL_W-1:0]   hold_col   = '0;

    // Clamp the height exponent; rows wrap modulo 2^h.
    function automatic int unsigned tex_hlog();
        return (cfg_thlog > HLOG_MAX) ? HLOG_MAX : cfg_thlog;
    endfunction

    // Latch a new column: texture column, Q16.16 step and start position.
    function automatic void latch_column(t_word w);
        int unsigned       tw;
        longint            lh;
        longint            n;
        longint            prod;
        longint unsigned   tcol;
        tw = (cfg_twidth == 0) ? 1 : (cfg_twidth > TEX_WIDTH_MAX) ? TEX_WIDTH_MAX : cfg_twidth;
        lh = (w.wall_rows == 0) ? 1 : longint'(w.wall_rows);
        tcol = (longint'(w.wall_fraction) * tw) >> FRAC_SH;
        // Mirror N/S faces on a positive x ray, E/W faces on a positive y ray.
        if ((w.face <= 1 && w.ray_x_positive) || (w.face >= 2 && w.ray_y_positive))
            tcol = tw - 1 - tcol;
        hold_tcol  = tcol[TEX_W-1:0];
        hold_col   = w.column;
        hold_start = w.span_start;
        hold_end   = w.span_end;
        hold_face  = w.face;
        step_q16   = 32'((64'd1 << (tex_hlog() + FRAC_SH)) / lh);
        n          = 2 * longint'(w.span_start) - longint'(SCREEN_ROWS) + lh;
        prod       = n * longint'(step_q16);
        tex_pos    = POS_W'(prod >>> 1);   // floor of half, two's complement
        row_cnt    = 0;
        col_active = 1'b1;
    endfunction

    // Advance one row; return 0 when no column is active.
    function automatic bit next_pixel(output t_pix px);
        longint p;
        px = '0;
        if (!col_active)
            return 1'b0;
        px.column = hold_col;
        px.row    = row_cnt[ROWO_W-1:0];
        px.face   = hold_face;
        if (row_cnt < hold_start) begin
            px.region     = RG_CEILING;
            px.flat_color = cfg_ceiling;
        end else if (row_cnt < hold_end) begin
            // Integer part truncates toward zero, then wraps to the texture height.
            p                = longint'($signed(tex_pos));
            px.region        = RG_WALL;
            px.texel_column  = hold_tcol;
            px.texel_row     = TEX_W'((p / 65536) & ((longint'(1) << tex_hlog()) - 1));
            tex_pos          = tex_pos + step_q16;
        end else begin
            px.region     = RG_FLOOR;
            px.flat_color = cfg_floor;
        end
        px.last = (row_cnt >= SCREEN_ROWS - 1);
        if (px.last) begin
            col_active = 1'b0;
            row_cnt    = 0;
        end else begin
            row_cnt = (row_cnt + 1) & 32'h3FF;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus words
    // ------------------------------------------------------------------
    t_word pending[$];          // words waiting for the driver
    t_pix  pixel_due[$];        // predicted pixels, oldest first

    function automatic t_word load_word(int col, int ss, int se, int lh, int frac,
                                        int face, bit xp, bit yp);
        t_word w;
        w.kind           = KIND_LOAD;
        w.column         = COL_W'(col);
        w.span_start     = SPAN_W'(ss);
        w.span_end       = SPAN_W'(se);
        w.wall_rows      = LH_W'(lh);
        w.wall_fraction  = FRAC_W'(frac);
        w.face           = FACE_W'(face);
        w.ray_x_positive = xp;
        w.ray_y_positive = yp;
        return w;
    endfunction

    // Tick fields other than kind are don't-care: fill them with noise.
    function automatic void queue_ticks(int count);
        t_word w;
        repeat (count) begin
            w      = t_word'({$urandom, $urandom, $urandom});
            w.kind = KIND_TICK;
            pending.push_back(w);
        end
    endfunction

    // Random load, biased toward spans that start near the top so short columns reach the wall.
    function automatic t_word rand_load();
        int ss;
        int se;
        int lh;
        ss = ($urandom_range(99) < 65) ? $urandom_range(0, 24) : $urandom_range(0, 1024);
        case ($urandom_range(3))
            0: se = (ss + $urandom_range(0, 40) > 1024) ? 1024 : ss + $urandom_range(0, 40);
            1: se = $urandom_range(0, 1024);
            2: se = 1024;
            default: se = $urandom_range(0, ss);   // start at or after end
        endcase
        case ($urandom_range(4))
            0: lh = $urandom_range(1, 16);
            1: lh = $urandom_range(17, 1024);
            2: lh = $urandom_range(1025, 65535);
            3: lh = $urandom_range(1) ? 65535 : 0;
            default: lh = $urandom_range(0, 65535);
        endcase
        return load_word($urandom_range(1023), ss, se, lh, $urandom_range(65535),
                         $urandom_range(3), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Mostly short columns cut off by the next load; optionally one column run to its
    // bottom row.
    task automatic queue_phase(int words, bit full_col);
        int queued;
        int ticks;
        int pick;
        queued = 0;
        while (queued < words) begin
            pending.push_back(rand_load());
            pick = $urandom_range(99);
            if (pick < 10)      ticks = 0;
            else if (pick < 75) ticks = $urandom_range(1, 40);
            else if (pick < 95) ticks = $urandom_range(41, 160);
            else                ticks = $urandom_range(161, 400);
            if (ticks > words - queued - 1)
                ticks = words - queued - 1;
            queue_ticks(ticks);
            queued += 1 + ticks;
        end
        // Run past the bottom row so a few ticks land on an idle block.
        if (full_col) begin
            pending.push_back(rand_load());
            queue_ticks(SCREEN_ROWS + $urandom_range(1, 4));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words from the pending queue, predict on acceptance.
    // ------------------------------------------------------------------
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    bit    tx_busy     = 1'b0;    // a word is on the ports and not yet taken
    t_word cur_word;
    int    rx_hold_left = 0;

    always @(posedge i_clk) begin : drive_words
        t_pix px;
        bit   go;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                if (cur_word.kind == KIND_LOAD)
                    latch_column(cur_word);
                else if (next_pixel(px))
                    pixel_due.push_back(px);
                tx_busy = 1'b0;
            end
            // Hold the current word until taken; otherwise maybe idle, else offer the next one.
            // Keep offering during the receiver hold-off so the command queue fills up.
            if (!tx_busy) begin
                go = (pending.size() != 0) &&
                     (rx_hold_left != 0 || $urandom_range(99) >= tx_idle_pct);
                if (go) begin
                    cur_word          = pending.pop_front();
                    tx_busy           = 1'b1;
                    i_kind           <= cur_word.kind;
                    i_column         <= cur_word.column;
                    i_span_start     <= cur_word.span_start;
                    i_span_end       <= cur_word.span_end;
                    i_wall_rows      <= cur_word.wall_rows;
                    i_wall_fraction  <= cur_word.wall_fraction;
                    i_face           <= cur_word.face;
                    i_ray_x_positive <= cur_word.ray_x_positive;
                    i_ray_y_positive <= cur_word.ray_y_positive;
                end
                push <= go;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each popped pixel with the oldest prediction.
    // ------------------------------------------------------------------
    int mismatch_count = 0;
    bit rx_hold_arm    = 1'b0;
    bit rx_hold_done   = 1'b0;

    task automatic log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pix  want;
        string diff;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pixel_due.size() == 0) begin
                    log_mismatch($sformatf("pixel col %0d row %0d with nothing predicted",
                                           o_out_column, o_row));
                end else begin
                    want = pixel_due.pop_front();
                    diff = "";
                    if (o_out_column !== want.column)
                        diff = {diff, $sformatf(" column %0d/%0d", o_out_column, want.column)};
                    if (o_row !== want.row)
                        diff = {diff, $sformatf(" row %0d/%0d", o_row, want.row)};
                    if (o_region !== want.region)
                        diff = {diff, $sformatf(" region %0d/%0d", o_region, want.region)};
                    if (o_flat_color !== want.flat_color)
                        diff = {diff, $sformatf(" flat %h/%h", o_flat_color, want.flat_color)};
                    if (o_texel_column !== want.texel_column)
                        diff = {diff, $sformatf(" tcol %0d/%0d", o_texel_column,
                                                want.texel_column)};
                    if (o_texel_row !== want.texel_row)
                        diff = {diff, $sformatf(" trow %0d/%0d", o_texel_row, want.texel_row)};
                    if (o_out_face !== want.face)
                        diff = {diff, $sformatf(" face %0d/%0d", o_out_face, want.face)};
                    if (o_last !== want.last)
                        diff = {diff, $sformatf(" last %b/%b", o_last, want.last)};
                    if (diff != "")
                        log_mismatch($sformatf("col %0d row %0d (got/exp):%s",
                                               want.column, want.row, diff));
                end
            end
            // Start the single long hold-off when asked; count it down here.
            if (rx_hold_arm && !rx_hold_done) begin
                rx_hold_left = LONG_HOLD;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no handshake at all.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    // Wait until every word is taken and every pixel has arrived, then let the load pipe settle.
    task automatic wait_drained();
        while (tx_busy || pending.size() != 0 || pixel_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Write one register and mirror it; the block takes it at the next edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CEILING: cfg_ceiling = data;
            CFG_FLOOR:   cfg_floor   = data;
            CFG_TWIDTH:  cfg_twidth  = data[TW_W-1:0];
            CFG_THLOG:   cfg_thlog   = data[HLOG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(logic [COLOR_W-1:0] ceiling, logic [COLOR_W-1:0] floor_rgb,
                              logic [COLOR_W-1:0] twidth, logic [COLOR_W-1:0] thlog);
        write_reg(CFG_CEILING, ceiling);
        write_reg(CFG_FLOOR, floor_rgb);
        write_reg(CFG_TWIDTH, twidth);
        write_reg(CFG_THLOG, thlog);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : run_test
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0: reset registers; sender idles 28%, receiver 50%.
        tx_idle_pct = 28;
        rx_idle_pct = 50;
        queue_ticks(1);    // tick with no column loaded: dropped
        // Mirrored north face, widest span, tallest line, fraction at its top.
        pending.push_back(load_word(1023, 0, 1024, 65535, 65535, 0, 1'b1, 1'b0));
        queue_ticks(3);
        // Zero line height acts as 1; start past the screen and after the end; mirrored west.
        pending.push_back(load_word(0, 1024, 0, 0, 0, 3, 1'b0, 1'b1));
        queue_ticks(2);
        // Start after end: ceiling rows then floor rows, no wall.
        pending.push_back(load_word(341, 5, 3, 1, 32768, 1, 1'b0, 1'b1));
        queue_ticks(8);
        // Negative start position: rows must truncate toward zero; east face stays unmirrored.
        pending.push_back(load_word(682, 0, 4, 3, 4660, 2, 1'b1, 1'b0));
        queue_ticks(5);
        // Reload while the previous column is still active.
        pending.push_back(load_word(512, 2, 1024, 2048, 65535, 3, 1'b1, 1'b0));
        queue_ticks(2);
        queue_phase(RAND_PER_PHASE - 26, 1'b0);
        wait_drained();

        // Phase 1: out-of-range width and height exponent with junk in the upper data bits.
        write_regs(24'hFFFFFF, COLOR_W'($urandom),
                   {13'($urandom), 11'd2047}, {20'($urandom), 4'd15});
        queue_phase(RAND_PER_PHASE, 1'b0);
        wait_drained();

        // Phase 2: roles swap; receiver also holds off once for a long stretch.
        tx_idle_pct = 50;
        rx_idle_pct = 28;
        write_regs(24'h000000, 24'hFFFFFF, 24'd0, 24'd0);
        queue_phase(RAND_PER_PHASE, 1'b0);
        while (pending.size() > 40)
            @(posedge i_clk);
        rx_hold_arm <= 1'b1;
        wait_drained();

        // Phase 3: widest texture, tallest height.
        write_regs(COLOR_W'($urandom), COLOR_W'($urandom), 24'd1024, 24'd10);
        queue_phase(RAND_PER_PHASE, 1'b0);
        wait_drained();

        // Phase 4: no idling on either side, random in-range registers, one full column.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(COLOR_W'($urandom), COLOR_W'($urandom),
                   COLOR_W'($urandom_range(1, 1023)), COLOR_W'($urandom_range(0, 9)));
        write_reg(CFG_TWIDTH, 24'd1);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        queue_phase(RAND_PER_PHASE, 1'b1);
        wait_drained();

        if (pixel_due.size() != 0)
            log_mismatch($sformatf("%0d predicted pixels never arrived", pixel_due.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
src/twcs_pkg.sv
src/twcs_front.sv
src/twcs_div.sv
src/twcs_back.sv
src/textured_wall_column_stepper_unit.sv
src/twcs_checker.sv
verif/tb.sv
